FILE: hw/rtl/mfv_pkg.sv
// ----------------------------------------------------------------------------
// mfv_pkg: shared types and constants for the most frequent value finder
// Holds the payload structs, the search sequencer state type and the
// default store depth.
// ----------------------------------------------------------------------------
package mfv_pkg;

  // Default number of entries in the element store
  localparam int unsigned MAX_ELEMENTS_DEF = 256;

  // Width of one stored element
  localparam int unsigned ELEM_W = 32;

  // Input transfer payload
  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     last;
  } in_item_t;

  // Result transfer payload
  typedef struct packed {
    logic signed [ELEM_W-1:0] mode_value;
    logic                     overflow;
  } out_item_t;

  // Search sequencer states
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_FETCH,
    SEQ_WAIT,
    SEQ_SCAN,
    SEQ_EVAL,
    SEQ_DONE
  } seq_state_t;

  // Status from the search sequencer to the top level
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ELEM_W-1:0] mode;
  } seq_status_t;

endpackage

FILE: hw/rtl/mfv_ram.sv
// ----------------------------------------------------------------------------
// mfv_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mfv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/mfv_seq.sv
// ----------------------------------------------------------------------------
// mfv_seq: search sequencer for the most frequent value
// Walks the stored elements with one compare unit: for each candidate it
// streams the later entries past an equality compare, counts hits and keeps
// the best candidate (strictly greater count wins, so earlier ones keep ties).
// ----------------------------------------------------------------------------
module mfv_seq #(
  parameter int unsigned MaxElements = mfv_pkg::MAX_ELEMENTS_DEF,
  localparam int unsigned IW = (MaxElements > 1) ? $clog2(MaxElements) : 1,
  localparam int unsigned CW = $clog2(MaxElements + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_search,
  input  logic [CW-1:0]               n_count,
  input  logic [mfv_pkg::ELEM_W-1:0]  rdata,
  output logic [IW-1:0]               raddr,
  output mfv_pkg::seq_status_t        status
);

  mfv_pkg::seq_state_t state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] best_cnt_r, best_cnt_nxt;
  logic [mfv_pkg::ELEM_W-1:0] cand_r, cand_nxt;
  logic [mfv_pkg::ELEM_W-1:0] best_r, best_nxt;
  logic pv_r, pv_nxt;   // a read issued last cycle is on rdata now
  logic j_in_range;
  logic hit;

  assign j_in_range = (j_r < n_count);
  assign hit        = pv_r && (rdata == cand_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfv_pkg::SEQ_IDLE;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= pv_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    cnt_r      <= cnt_nxt;
    best_cnt_r <= best_cnt_nxt;
    cand_r     <= cand_nxt;
    best_r     <= best_nxt;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    cnt_nxt      = cnt_r;
    best_cnt_nxt = best_cnt_r;
    cand_nxt     = cand_r;
    best_nxt     = best_r;
    pv_nxt       = 1'b0;
    raddr        = i_r[IW-1:0];

    unique case (state_r)
      mfv_pkg::SEQ_IDLE: begin
        if (start_search) begin
          i_nxt        = '0;
          best_cnt_nxt = '0;
          state_nxt    = mfv_pkg::SEQ_FETCH;
        end
      end
      // read the candidate entry
      mfv_pkg::SEQ_FETCH: begin
        raddr     = i_r[IW-1:0];
        state_nxt = mfv_pkg::SEQ_WAIT;
      end
      // latch the candidate, start counting at one
      mfv_pkg::SEQ_WAIT: begin
        cand_nxt  = rdata;
        cnt_nxt   = CW'(1);
        j_nxt     = i_r + CW'(1);
        state_nxt = mfv_pkg::SEQ_SCAN;
      end
      // stream later entries past the compare, one read per cycle
      mfv_pkg::SEQ_SCAN: begin
        if (j_in_range) begin
          raddr  = j_r[IW-1:0];
          pv_nxt = 1'b1;
          j_nxt  = j_r + CW'(1);
        end
        if (hit) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (!j_in_range && !pv_r) begin
          state_nxt = mfv_pkg::SEQ_EVAL;
        end
      end
      // keep the candidate only on a strictly larger count
      mfv_pkg::SEQ_EVAL: begin
        if (cnt_r > best_cnt_r) begin
          best_cnt_nxt = cnt_r;
          best_nxt     = cand_r;
        end
        i_nxt = i_r + CW'(1);
        if ((i_r + CW'(1)) < n_count) begin
          state_nxt = mfv_pkg::SEQ_FETCH;
        end else begin
          state_nxt = mfv_pkg::SEQ_DONE;
        end
      end
      mfv_pkg::SEQ_DONE: begin
        state_nxt = mfv_pkg::SEQ_IDLE;
      end
      default: begin
        state_nxt = mfv_pkg::SEQ_IDLE;
      end
    endcase
  end

  assign status.busy = (state_r != mfv_pkg::SEQ_IDLE);
  assign status.done = (state_r == mfv_pkg::SEQ_DONE);
  assign status.mode = best_r;

endmodule

FILE: hw/rtl/most_frequent_value_finder_unit.sv
// ----------------------------------------------------------------------------
// most_frequent_value_finder_unit: mode of a set of signed 32-bit values
// Loads one element per transfer into the element store; after the element
// marked last it searches the store and emits the most frequent value.
//
//   channel | ports                  | transfer when
//   --------+------------------------+-------------------------------
//   input   | start, busy, in_data   | start && !busy
//   result  | out_valid, out_data    | out_valid (one cycle, no stall)
//
// Elements load while busy is low; elements past MAX_ELEMENTS are
// dropped and flagged. After the last element busy stays high while the
// n stored elements are searched, one store read per cycle into
// a single equality compare; out_valid pulses in the last busy cycle and
// busy falls in the next. The receiver cannot stall results. Reset is
// synchronous, active low, and zeroes the fill count; no clearing pass.
// ----------------------------------------------------------------------------
module most_frequent_value_finder_unit #(
  parameter int unsigned MAX_ELEMENTS = mfv_pkg::MAX_ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mfv_pkg::in_item_t  in_data,
  output logic               out_valid,
  output mfv_pkg::out_item_t out_data
);

  localparam int unsigned IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  logic [CW-1:0] fill_r, fill_nxt;
  logic dropped_r, dropped_nxt;
  logic accept;
  logic full;
  logic wr_en;
  logic [IW-1:0] raddr;
  logic [mfv_pkg::ELEM_W-1:0] rdata;
  mfv_pkg::seq_status_t seq_status;

  assign accept = start && !busy;
  assign full   = (fill_r == CW'(MAX_ELEMENTS));
  assign wr_en  = accept && !full;

  // Fill count and overflow flag; cleared once the result goes out
  always_comb begin
    fill_nxt    = fill_r;
    dropped_nxt = dropped_r;
    if (seq_status.done) begin
      fill_nxt    = '0;
      dropped_nxt = 1'b0;
    end else if (accept) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        fill_nxt = fill_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      dropped_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Element store
  mfv_ram #(
    .Width (mfv_pkg::ELEM_W),
    .Depth (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (fill_r[IW-1:0]),
    .wdata (in_data.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Search sequencer
  mfv_seq #(
    .MaxElements (MAX_ELEMENTS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_search (accept && in_data.last),
    .n_count      (fill_r),
    .rdata        (rdata),
    .raddr        (raddr),
    .status       (seq_status)
  );

  assign busy                = seq_status.busy;
  assign out_valid           = seq_status.done;
  assign out_data.mode_value = seq_status.mode;
  assign out_data.overflow   = dropped_r;

endmodule

FILE: hw/rtl/mfv_checker.sv
// ----------------------------------------------------------------------------
// mfv_checker: port-level checks for the most frequent value finder
// Watches the handshake and result strobe over time.
// ----------------------------------------------------------------------------
module mfv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input mfv_pkg::in_item_t  in_data,
  input logic               out_valid,
  input mfv_pkg::out_item_t out_data
);

  // A result only appears while the block is busy, and carries known data
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy && !$isunknown(out_data)))
    else $error("result strobe while not busy or with unknown data");

  // The result strobe lasts exactly one cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // The last element of a set starts the search
  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last) |=> (busy && !out_valid))
    else $error("search did not start after last element");

  // The block is free again right after a result transfer
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("still busy after result transfer");

  // Without a last element no result follows
  a_no_result_on_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.last) |=> (!busy && !out_valid))
    else $error("unexpected activity after plain element");

endmodule

bind most_frequent_value_finder_unit mfv_checker u_mfv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
